/* rtl/core/imu_fd_pkg.sv */
// Package with shared types, constants and functions of the IMU frame deframer.
`timescale 1ns / 1ps

package imu_fd_pkg;

    // Frame layout defaults and fixed codes.
    localparam int unsigned WORDS_PER_FRAME_DEF = 11;
    localparam int unsigned TRAILER_BYTES_DEF   = 2;
    localparam int unsigned QUAT_WORDS          = 4;
    localparam logic [7:0]  SYNC_BYTE           = 8'h41;
    localparam logic [30:0] LIMIT_RESET         = 31'h461C_3C00;
    localparam logic [31:0] IDENTITY_ONE        = 32'h3F80_0000;

    // Configuration port layout.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_LIMIT  = 1'b0;

    // Output queue geometry.
    localparam int unsigned OUTQ_DEPTH = 8;
    localparam int unsigned OUTQ_PTR_W = 3;
    localparam int unsigned OUTQ_CNT_W = 4;

    // One result transaction.
    typedef struct packed {
        logic [3:0]  word_index;
        logic [31:0] word_value;
        logic        was_replaced;
        logic        frame_last;
    } out_item_t;

    // Push request from the deframer into the output queue.
    typedef struct packed {
        logic [2:0]  push_n;
        out_item_t   item0;
        out_item_t   item1;
        out_item_t   item2;
        out_item_t   item3;
    } outq_push_t;

    // A word is invalid when it is a NaN or, while the limit is no NaN, a positive word above the limit pattern.
    function automatic logic word_invalid(input logic [31:0] w, input logic [30:0] limit);
        logic w_nan;
        logic lim_nan;
        logic over;
        w_nan   = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
        lim_nan = (limit[30:23] == 8'hFF) && (limit[22:0] != 23'd0);
        over    = !w[31] && (w[30:0] > limit);
        return w_nan || (!lim_nan && over);
    endfunction

endpackage

/* rtl/core/imu_fd_if.sv */
// Valid/ready channel interfaces for byte input and word results.
`timescale 1ns / 1ps

interface imu_fd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_fd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic        was_replaced;
    logic        frame_last;

    modport source (output valid, output word_index, output word_value,
                    output was_replaced, output frame_last, input ready);
    modport sink   (input valid, input word_index, input word_value,
                    input was_replaced, input frame_last, output ready);
endinterface

/* rtl/core/imu_fd_outq.sv */
// Result queue that takes up to four results per cycle and sends one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module imu_fd_outq
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  imu_fd_pkg::outq_push_t         push,
    output logic                           space4,
    imu_fd_out_if.source                   out_ch
);

    imu_fd_pkg::out_item_t                     mem_reg [imu_fd_pkg::OUTQ_DEPTH];
    imu_fd_pkg::out_item_t                     items   [4];
    logic [imu_fd_pkg::OUTQ_PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [imu_fd_pkg::OUTQ_PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [imu_fd_pkg::OUTQ_CNT_W-1:0]         count_reg, count_next;
    logic                                      pop;

    assign items[0] = push.item0;
    assign items[1] = push.item1;
    assign items[2] = push.item2;
    assign items[3] = push.item3;

    // Head of queue drives the output channel.
    assign pop                 = out_ch.valid && out_ch.ready;
    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.word_index   = mem_reg[rd_ptr_reg].word_index;
    assign out_ch.word_value   = mem_reg[rd_ptr_reg].word_value;
    assign out_ch.was_replaced = mem_reg[rd_ptr_reg].was_replaced;
    assign out_ch.frame_last   = mem_reg[rd_ptr_reg].frame_last;

    // Room for a full quaternion burst.
    assign space4 = (count_reg <= imu_fd_pkg::OUTQ_CNT_W'(imu_fd_pkg::OUTQ_DEPTH - 4));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + imu_fd_pkg::OUTQ_PTR_W'(push.push_n);
        rd_ptr_next = rd_ptr_reg + imu_fd_pkg::OUTQ_PTR_W'(pop);
        count_next  = count_reg + imu_fd_pkg::OUTQ_CNT_W'(push.push_n)
                      - imu_fd_pkg::OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes, one slot per pushed result.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) < push.push_n)
            begin
                mem_reg[wr_ptr_reg + imu_fd_pkg::OUTQ_PTR_W'(k)] <= items[k];
            end
        end
    end

endmodule

/* rtl/core/imu_frame_deframer_core.sv */
// Top level of the IMU frame deframer: sync hunt, word assembly and screening.
`timescale 1ns / 1ps

// The block accepts one received byte per clock cycle while the result queue
// has room and writes a word's results into that queue when its last byte is
// taken. A frame starts after two consecutive 'A' bytes, carries WORDS_PER_FRAME
// big-endian IEEE single words and ends with TRAILER_BYTES unchecked bytes.
// The fourth quaternion word releases four results at once; these leave the
// eight-entry result queue at one per cycle while the receiver is ready, so a
// byte is accepted whenever the queue holds four results or fewer. Sustained
// rate is one byte per cycle as long as results are taken. The limit register
// (address 0) holds the positive limit bit pattern.
module imu_frame_deframer_core
#(
    parameter int unsigned WORDS_PER_FRAME = imu_fd_pkg::WORDS_PER_FRAME_DEF,
    parameter int unsigned TRAILER_BYTES   = imu_fd_pkg::TRAILER_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imu_fd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [imu_fd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [imu_fd_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    imu_fd_in_if.sink                         in_ch,
    imu_fd_out_if.source                      out_ch
);

    localparam int unsigned CNT_W  = $clog2(WORDS_PER_FRAME * 4 + 1);
    localparam int unsigned WIDX_W = CNT_W - 2;

    typedef enum logic [1:0] {PH_HUNT, PH_DATA, PH_TRAIL} phase_t;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             prev_byte_reg, prev_byte_next;
    logic [CNT_W-1:0]       byte_count_reg, byte_count_next;
    logic [23:0]            word_shift_reg, word_shift_next;
    logic                   quat_bad_reg, quat_bad_next;
    logic [30:0]            limit_reg;
    logic [31:0]            quat_store_reg [imu_fd_pkg::QUAT_WORDS];

    logic                   accept;
    logic                   space4;
    logic [31:0]            word;
    logic                   bad;
    logic                   bad_any;
    logic [WIDX_W-1:0]      widx;
    logic                   last_word;
    logic                   word_done;
    logic                   quat_wr;
    imu_fd_pkg::outq_push_t push;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == imu_fd_pkg::REG_LIMIT) ? {1'b0, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= imu_fd_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == imu_fd_pkg::REG_LIMIT)
        begin
            limit_reg <= pwdata[30:0];
        end
    end

    assign in_ch.ready = space4;
    assign accept      = in_ch.valid && in_ch.ready;

    // Word assembly and screening.
    assign word      = {word_shift_reg, in_ch.rx_byte};
    assign bad       = imu_fd_pkg::word_invalid(word, limit_reg);
    assign bad_any   = quat_bad_reg || bad;
    assign widx      = byte_count_reg[CNT_W-1:2];
    assign last_word = (widx == WIDX_W'(WORDS_PER_FRAME - 1));
    assign word_done = accept && (phase_reg == PH_DATA) && (byte_count_reg[1:0] == 2'd3);
    assign quat_wr   = word_done && (widx < WIDX_W'(imu_fd_pkg::QUAT_WORDS));

    // Sequencing of hunt, data and trailer phases.
    always_comb
    begin
        phase_next      = phase_reg;
        prev_byte_next  = prev_byte_reg;
        byte_count_next = byte_count_reg;
        word_shift_next = word_shift_reg;
        quat_bad_next   = quat_bad_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (prev_byte_reg == imu_fd_pkg::SYNC_BYTE
                        && in_ch.rx_byte == imu_fd_pkg::SYNC_BYTE)
                    begin
                        phase_next      = PH_DATA;
                        byte_count_next = '0;
                        word_shift_next = '0;
                        quat_bad_next   = 1'b0;
                        prev_byte_next  = '0;
                    end
                    else
                    begin
                        prev_byte_next = in_ch.rx_byte;
                    end
                end
                PH_DATA:
                begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                    if (byte_count_reg[1:0] != 2'd3)
                    begin
                        word_shift_next = {word_shift_reg[15:0], in_ch.rx_byte};
                    end
                    else
                    begin
                        word_shift_next = '0;
                        if (quat_wr && bad)
                        begin
                            quat_bad_next = 1'b1;
                        end
                        if (last_word)
                        begin
                            byte_count_next = '0;
                            prev_byte_next  = '0;
                            phase_next      = (TRAILER_BYTES > 0) ? PH_TRAIL : PH_HUNT;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                    if (byte_count_next >= CNT_W'(TRAILER_BYTES))
                    begin
                        phase_next      = PH_HUNT;
                        prev_byte_next  = '0;
                        byte_count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            prev_byte_reg  <= '0;
            byte_count_reg <= '0;
            word_shift_reg <= '0;
            quat_bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            prev_byte_reg  <= prev_byte_next;
            byte_count_reg <= byte_count_next;
            word_shift_reg <= word_shift_next;
            quat_bad_reg   <= quat_bad_next;
        end
    end

    // Quaternion hold registers.
    always_ff @(posedge clk)
    begin
        if (quat_wr)
        begin
            quat_store_reg[widx[1:0]] <= word;
        end
    end

    // Results pushed for the completed word.
    always_comb
    begin
        push = '0;
        if (word_done)
        begin
            if (quat_wr)
            begin
                if (widx[1:0] == 2'd3)
                begin
                    push.push_n             = 3'd4;
                    push.item0.word_index   = 4'd0;
                    push.item1.word_index   = 4'd1;
                    push.item2.word_index   = 4'd2;
                    push.item3.word_index   = 4'd3;
                    push.item0.was_replaced = bad_any;
                    push.item1.was_replaced = bad_any;
                    push.item2.was_replaced = bad_any;
                    push.item3.was_replaced = bad_any;
                    push.item0.word_value   = bad_any ? imu_fd_pkg::IDENTITY_ONE
                                                      : quat_store_reg[0];
                    push.item1.word_value   = bad_any ? '0 : quat_store_reg[1];
                    push.item2.word_value   = bad_any ? '0 : quat_store_reg[2];
                    push.item3.word_value   = bad_any ? '0 : word;
                end
            end
            else
            begin
                push.push_n             = 3'd1;
                push.item0.word_index   = 4'(widx);
                push.item0.word_value   = bad ? '0 : word;
                push.item0.was_replaced = bad;
                push.item0.frame_last   = last_word;
            end
        end
    end

    imu_fd_outq u_outq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space4 (space4),
        .out_ch (out_ch)
    );

endmodule
